### src/oscillometric_bp_estimator_macros.svh
// Assertion macros for the estimator RTL.
// Needs a clock named aclk and an active-low reset named aresetn in scope.
`ifndef OSCILLOMETRIC_BP_ESTIMATOR_MACROS_SVH
`define OSCILLOMETRIC_BP_ESTIMATOR_MACROS_SVH

// condition must hold at every edge out of reset
`define BPE_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("bpe invariant violated");

// antecedent implies consequent on the following edge
`define BPE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("bpe sequencing violated");

`endif

### src/bpe_pkg.sv
// Shared types and constants of the oscillometric estimator.
// No dependencies.
package bpe_pkg;

    localparam int MAX_SAMPLES_DEF = 2048;
    localparam int DC_SPAN_DEF     = 40;
    localparam int ENV_SPAN_DEF    = 20;

    localparam int SAMPLE_W = 9;
    localparam int VAL_W    = 17;
    localparam int RATIO_W  = 9;
    localparam int THR_W    = RATIO_W + VAL_W;
    localparam int FRAC_W   = 8;

    localparam logic [RATIO_W-1:0] SYS_RATIO_RST = 9'd128;
    localparam logic [RATIO_W-1:0] DIA_RATIO_RST = 9'd205;

    // configuration register indexes
    typedef enum logic [0:0] {
        REG_SYS_RATIO = 1'b0,
        REG_DIA_RATIO = 1'b1
    } reg_idx_t;

    // memory read address source
    typedef enum logic [1:0] {
        RD_HI,
        RD_LO,
        RD_I
    } rd_sel_t;

    typedef struct packed {
        logic    load;
        logic    rec_clr;
        logic    pass_clr;
        logic    env_mode;
        rd_sel_t rd_sel;
        logic    acc_add;
        logic    acc_sub;
        logic    div_start;
        logic    wr_res;
        logic    pk_cmp;
        logic    thr_sys;
        logic    thr_dia;
        logic    walk_dn;
        logic    walk_up;
        logic    cap_sys;
        logic    cap_dia;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic need_add;
        logic need_sub;
        logic i_last;
        logic div_done;
        logic dn_ok;
        logic up_ok;
        logic out_free;
    } status_t;

endpackage

### src/bpe_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on nothing; used by the estimator datapath.
module bpe_div #(
    parameter int DVW = 24,
    parameter int DSW = 13
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  logic [DVW-1:0] dividend,
    input  logic [DSW-1:0] divisor,
    output logic           busy,
    output logic [DVW-1:0] quotient
);
    localparam int CNTW = $clog2(DVW + 1);

    logic [CNTW-1:0] cnt_reg;
    logic [DVW-1:0]  q_reg;
    logic [DSW-1:0]  rem_reg;
    logic [DSW-1:0]  dsr_reg;
    logic [DSW:0]    shifted;
    logic [DSW:0]    trial;

    assign shifted = {rem_reg, q_reg[DVW-1]};
    assign trial   = shifted - {1'b0, dsr_reg};

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            cnt_reg <= CNTW'(DVW);
        end else if (cnt_reg != '0) begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // shift-subtract step
    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg   <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end else if (cnt_reg != '0) begin
            if (!trial[DSW]) begin
                rem_reg <= trial[DSW-1:0];
                q_reg   <= {q_reg[DVW-2:0], 1'b1};
            end else begin
                rem_reg <= shifted[DSW-1:0];
                q_reg   <= {q_reg[DVW-2:0], 1'b0};
            end
        end
    end

    assign busy     = (cnt_reg != '0);
    assign quotient = q_reg;
endmodule

### src/bpe_dp.sv
// Estimator datapath: record stores, window sums, peak and walk registers.
// Depends on bpe_pkg, bpe_div and the macros header.
`include "oscillometric_bp_estimator_macros.svh"
module bpe_dp #(
    parameter int MAX_SAMPLES = bpe_pkg::MAX_SAMPLES_DEF,
    parameter int DC_SPAN     = bpe_pkg::DC_SPAN_DEF,
    parameter int ENV_SPAN    = bpe_pkg::ENV_SPAN_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  bpe_pkg::cmd_t                cmd,
    output bpe_pkg::status_t             st,
    input  logic [bpe_pkg::SAMPLE_W-1:0] sample,
    input  logic [bpe_pkg::RATIO_W-1:0]  sys_ratio,
    input  logic [bpe_pkg::RATIO_W-1:0]  dia_ratio,
    input  logic                         m_tready,
    output logic                         m_tvalid,
    output logic [bpe_pkg::VAL_W-1:0]    sys_out,
    output logic [bpe_pkg::VAL_W-1:0]    dia_out,
    output logic                         ovf_out
);
    import bpe_pkg::*;

    localparam int AW      = $clog2(MAX_SAMPLES);
    localparam int CW      = $clog2(MAX_SAMPLES + 1);
    localparam int H_DC    = DC_SPAN / 2;
    localparam int H_ENV   = ENV_SPAN / 2;
    localparam int SPANMAX = (DC_SPAN > ENV_SPAN) ? DC_SPAN : ENV_SPAN;
    localparam int SW      = VAL_W + 1 + $clog2(SPANMAX);

    logic [SAMPLE_W-1:0] smem [MAX_SAMPLES];
    logic [VAL_W-1:0]    dmem [MAX_SAMPLES];
    logic [VAL_W-1:0]    emem [MAX_SAMPLES];

    logic [SAMPLE_W-1:0] s_q;
    logic [VAL_W-1:0]    d_q;
    logic [VAL_W-1:0]    e_q;

    logic [CW-1:0]    n_reg, i_reg, lo_reg, hi_reg, pidx_reg;
    logic             ovf_reg;
    logic [SW-1:0]    sum_reg;
    logic [VAL_W-1:0] peak_reg;
    logic [THR_W-1:0] thr_reg;
    logic [VAL_W-1:0] sys_reg, dia_reg;
    logic             mv_reg;

    logic [AW-1:0]    rd_addr;
    logic [CW:0]      half;
    logic [VAL_W-1:0] s_scaled;
    logic [VAL_W-1:0] abs_ac;
    logic [VAL_W-1:0] acc_val;
    logic [SW-1:0]    dividend;
    logic [CW-1:0]    win_cnt;
    logic             div_busy;
    logic [SW-1:0]    quotient;
    logic             env_ge;

    // read address and operand selection
    always_comb begin
        case (cmd.rd_sel)
            RD_HI:   rd_addr = hi_reg[AW-1:0];
            RD_LO:   rd_addr = lo_reg[AW-1:0];
            RD_I:    rd_addr = i_reg[AW-1:0];
            default: rd_addr = i_reg[AW-1:0];
        endcase
    end

    assign half     = cmd.env_mode ? (CW+1)'(H_ENV) : (CW+1)'(H_DC);
    assign s_scaled = {s_q, {FRAC_W{1'b0}}};
    assign abs_ac   = (s_scaled >= d_q) ? (s_scaled - d_q) : (d_q - s_scaled);
    assign acc_val  = cmd.env_mode ? abs_ac : VAL_W'(s_q);
    assign dividend = cmd.env_mode ? sum_reg : {sum_reg[SW-FRAC_W-1:0], {FRAC_W{1'b0}}};
    assign win_cnt  = hi_reg - lo_reg;
    assign env_ge   = ({1'b0, e_q, {FRAC_W{1'b0}}} >= thr_reg);

    // status to the controller
    always_comb begin
        st.need_add = (hi_reg < n_reg) && ({1'b0, hi_reg} < ({1'b0, i_reg} + half));
        st.need_sub = (({1'b0, lo_reg} + half) < {1'b0, i_reg});
        st.i_last   = ((i_reg + 1'b1) == n_reg);
        st.div_done = !div_busy;
        st.dn_ok    = (i_reg != '0) && env_ge;
        st.up_ok    = !st.i_last && env_ge;
        st.out_free = !mv_reg || m_tready;
    end

    // stores: one write port, registered read
    always_ff @(posedge aclk) begin
        if (cmd.load && (n_reg < CW'(MAX_SAMPLES))) begin
            smem[n_reg[AW-1:0]] <= sample;
        end
        if (cmd.wr_res && !cmd.env_mode) begin
            dmem[i_reg[AW-1:0]] <= quotient[VAL_W-1:0];
        end
        if (cmd.wr_res && cmd.env_mode) begin
            emem[i_reg[AW-1:0]] <= quotient[VAL_W-1:0];
        end
        s_q <= smem[rd_addr];
        d_q <= dmem[rd_addr];
        e_q <= emem[rd_addr];
    end

    bpe_div #(
        .DVW (SW),
        .DSW (CW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (win_cnt),
        .busy     (div_busy),
        .quotient (quotient)
    );

    // record length and overflow
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.rec_clr) begin
            n_reg   <= '0;
            ovf_reg <= 1'b0;
        end else if (cmd.load) begin
            if (n_reg < CW'(MAX_SAMPLES)) begin
                n_reg <= n_reg + 1'b1;
            end else begin
                ovf_reg <= 1'b1;
            end
        end
    end

    // window and scan indexes
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.pass_clr) begin
            i_reg   <= '0;
            lo_reg  <= '0;
            hi_reg  <= '0;
            sum_reg <= '0;
        end else begin
            if (cmd.acc_add) begin
                sum_reg <= sum_reg + SW'(acc_val);
                hi_reg  <= hi_reg + 1'b1;
            end
            if (cmd.acc_sub) begin
                sum_reg <= sum_reg - SW'(acc_val);
                lo_reg  <= lo_reg + 1'b1;
            end
            if (cmd.wr_res || cmd.pk_cmp || cmd.walk_up) begin
                i_reg <= i_reg + 1'b1;
            end
            if (cmd.walk_dn) begin
                i_reg <= i_reg - 1'b1;
            end
            if (cmd.thr_sys || cmd.thr_dia) begin
                i_reg <= pidx_reg;
            end
        end
    end

    // peak, thresholds and captured results
    always_ff @(posedge aclk) begin
        if (cmd.pk_cmp && ((i_reg == '0) || (e_q > peak_reg))) begin
            peak_reg <= e_q;
            pidx_reg <= i_reg;
        end
        if (cmd.thr_sys) begin
            thr_reg <= sys_ratio * peak_reg;
        end
        if (cmd.thr_dia) begin
            thr_reg <= dia_ratio * peak_reg;
        end
        if (cmd.cap_sys) begin
            sys_reg <= d_q;
        end
        if (cmd.cap_dia) begin
            dia_reg <= d_q;
        end
    end

    // output word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_reg <= 1'b0;
        end else if (cmd.out_load) begin
            mv_reg <= 1'b1;
        end else if (m_tready) begin
            mv_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            sys_out <= sys_reg;
            dia_out <= dia_reg;
            ovf_out <= ovf_reg;
        end
    end

    assign m_tvalid = mv_reg;

    `BPE_ASSERT_ALWAYS(a_count_bound, n_reg <= CW'(MAX_SAMPLES))
    `BPE_ASSERT_ALWAYS(a_window_order, lo_reg <= hi_reg)
    `BPE_ASSERT_NEXT(a_out_loaded, cmd.out_load, mv_reg)
endmodule

### src/bpe_ctrl.sv
// Estimator sequencer: load, DC pass, envelope pass, peak scan, two walks.
// Depends on bpe_pkg; drives bpe_dp by command and reads its status.
module bpe_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    input  logic             s_tlast,
    output logic             s_tready,
    input  bpe_pkg::status_t st,
    output bpe_pkg::cmd_t    cmd
);
    import bpe_pkg::*;

    typedef enum logic [3:0] {
        S_LOAD, S_CHK, S_ADD, S_SUB, S_DIV, S_PK_RD, S_PK_CMP,
        S_TS, S_WD_RD, S_WD_CMP, S_TD, S_WU_RD, S_WU_CMP, S_FIN
    } state_t;

    state_t state_reg, state_next;
    logic   mode_reg, mode_next;
    logic   acc;

    assign acc      = s_tvalid && (state_reg == S_LOAD);
    assign s_tready = (state_reg == S_LOAD);

    // next state and commands
    always_comb begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        cmd          = '0;
        cmd.env_mode = mode_reg;
        cmd.rd_sel   = RD_I;
        case (state_reg)
            S_LOAD: begin
                if (acc) begin
                    cmd.load = 1'b1;
                    if (s_tlast) begin
                        cmd.pass_clr = 1'b1;
                        mode_next    = 1'b0;
                        state_next   = S_CHK;
                    end
                end
            end
            S_CHK: begin
                if (st.need_add) begin
                    cmd.rd_sel = RD_HI;
                    state_next = S_ADD;
                end else if (st.need_sub) begin
                    cmd.rd_sel = RD_LO;
                    state_next = S_SUB;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_ADD: begin
                cmd.acc_add = 1'b1;
                state_next  = S_CHK;
            end
            S_SUB: begin
                cmd.acc_sub = 1'b1;
                state_next  = S_CHK;
            end
            S_DIV: begin
                if (st.div_done) begin
                    cmd.wr_res = 1'b1;
                    if (st.i_last) begin
                        cmd.pass_clr = 1'b1;
                        mode_next    = 1'b1;
                        state_next   = mode_reg ? S_PK_RD : S_CHK;
                    end else begin
                        state_next = S_CHK;
                    end
                end
            end
            S_PK_RD: begin
                state_next = S_PK_CMP;
            end
            S_PK_CMP: begin
                cmd.pk_cmp = 1'b1;
                state_next = st.i_last ? S_TS : S_PK_RD;
            end
            S_TS: begin
                cmd.thr_sys = 1'b1;
                state_next  = S_WD_RD;
            end
            S_WD_RD: begin
                state_next = S_WD_CMP;
            end
            S_WD_CMP: begin
                if (st.dn_ok) begin
                    cmd.walk_dn = 1'b1;
                    state_next  = S_WD_RD;
                end else begin
                    cmd.cap_sys = 1'b1;
                    state_next  = S_TD;
                end
            end
            S_TD: begin
                cmd.thr_dia = 1'b1;
                state_next  = S_WU_RD;
            end
            S_WU_RD: begin
                state_next = S_WU_CMP;
            end
            S_WU_CMP: begin
                if (st.up_ok) begin
                    cmd.walk_up = 1'b1;
                    state_next  = S_WU_RD;
                end else begin
                    cmd.cap_dia = 1'b1;
                    state_next  = S_FIN;
                end
            end
            S_FIN: begin
                if (st.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.rec_clr  = 1'b1;
                    state_next   = S_LOAD;
                end
            end
            default: state_next = S_LOAD;
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
            mode_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
        end
    end
endmodule

### src/oscillometric_bp_estimator.sv
// Oscillometric blood pressure estimator, fixed-ratio method: a sample word
// is taken on each handshake while loading. After the word marked tlast the
// block stops accepting and runs a DC pass and an envelope pass over the n
// stored samples; for each index it adds or drops window samples one at a
// time, starts the divide and runs a serial divide of SW quotient bits (SW =
// 18 + clog2(max span), 24 by default), and then a peak scan and two walks.
// The result word sits in an output register and the next record may load
// while it waits. Ratios are to be written on the cfg channel only while idle; the block itself does not enforce it.
// Depends on bpe_pkg, bpe_ctrl, bpe_dp and bpe_div.
module oscillometric_bp_estimator #(
    parameter int MAX_SAMPLES = bpe_pkg::MAX_SAMPLES_DEF,
    parameter int DC_SPAN     = bpe_pkg::DC_SPAN_DEF,
    parameter int ENV_SPAN    = bpe_pkg::ENV_SPAN_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [8:0] pressure_sample, rest zero
    input  logic        s_tlast,   // last_sample
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [16:0] systolic_mmhg, [33:17] diastolic_mmhg
    output logic        m_tuser,   // overflowed
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [8:0]  cfg_data
);
    import bpe_pkg::*;

    cmd_t                cmd;
    status_t             st;
    logic [RATIO_W-1:0]  sys_ratio_reg, dia_ratio_reg;
    logic [VAL_W-1:0]    sys_out, dia_out;

    // ratio registers
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sys_ratio_reg <= SYS_RATIO_RST;
            dia_ratio_reg <= DIA_RATIO_RST;
        end else if (cfg_valid) begin
            case (reg_idx_t'(cfg_index))
                REG_SYS_RATIO: sys_ratio_reg <= cfg_data;
                REG_DIA_RATIO: dia_ratio_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    bpe_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    bpe_dp #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .DC_SPAN     (DC_SPAN),
        .ENV_SPAN    (ENV_SPAN)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .st        (st),
        .sample    (s_tdata[SAMPLE_W-1:0]),
        .sys_ratio (sys_ratio_reg),
        .dia_ratio (dia_ratio_reg),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .sys_out   (sys_out),
        .dia_out   (dia_out),
        .ovf_out   (m_tuser)
    );

    assign m_tdata = {6'd0, dia_out, sys_out};
endmodule
